// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hrol_pkg.sv =====
// Shared constants for the hash ring owner lookup block.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package hrol_pkg;

   localparam int RING_DEPTH_DEF = 64;

   localparam int KEY_W = 32;
   localparam int MAC_W = 48;
   localparam int IDX_W = 6;
   localparam int LEN_W = 7;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   localparam logic ST_FOUND = 1'b0;
   localparam logic ST_EMPTY = 1'b1;

endpackage
`default_nettype wire

// ===== hw/rtl/hrol_ring_mem.sv =====
// Ring table memory: one write port and one registered read port.
// Depends on hrol_pkg for the key and MAC widths.
`default_nettype none
module hrol_ring_mem
   import hrol_pkg::*;
#(
   parameter int DEPTH = RING_DEPTH_DEF,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [KEY_W-1:0] wr_key,
   input  wire logic [MAC_W-1:0] wr_mac,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [KEY_W-1:0] rd_key,
   output logic      [MAC_W-1:0] rd_mac
);

   logic [KEY_W-1:0] keys_mem [DEPTH];
   logic [MAC_W-1:0] macs_mem [DEPTH];
   logic [KEY_W-1:0] rd_key_ff;
   logic [MAC_W-1:0] rd_mac_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         keys_mem[wr_addr] <= wr_key;
         macs_mem[wr_addr] <= wr_mac;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff <= keys_mem[rd_addr];
         rd_mac_ff <= macs_mem[rd_addr];
      end
   end

   assign rd_key = rd_key_ff;
   assign rd_mac = rd_mac_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/hash_ring_owner_lookup.sv =====
// Hash ring owner lookup: ring table, scan sequencer and response register.
// Depends on hrol_pkg and instantiates hrol_ring_mem.
//
// Usage. Requests arrive on the req_ channel (valid/ready). A request with
// req_func set to write stores req_entry_key and req_entry_mac at
// req_entry_index and produces no response. A lookup request scans the ring
// from entry 0 and answers on the rsp_ channel with the MAC of the first entry
// whose key is strictly greater than req_lookup_key, or with the last valid
// entry's MAC when none is greater. The ring length comes from the csr_
// register, which must be written only while the block is idle; the block
// itself does not enforce this.
// Scan. A lookup reads one ring entry per cycle through the single read port
// of the ring memory while the one key comparator checks the previous entry.
// A hit or an empty ring fills a result register, which moves to the output
// register once that is free; req_ready stays low from acceptance until that move.
// Writes are taken every cycle while idle.
// Stalls. A finished response waits in the output register while rsp_ready is
// low; the block keeps accepting requests meanwhile and a following lookup
// holds its result until the output register frees up.
// Reset clears the ring length, the sequencer and the response valid; the
// ring contents are undefined until written.
`default_nettype none
module hash_ring_owner_lookup
   import hrol_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [LEN_W-1:0] csr_wr_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_func,
   input  wire logic [IDX_W-1:0] req_entry_index,
   input  wire logic [KEY_W-1:0] req_entry_key,
   input  wire logic [MAC_W-1:0] req_entry_mac,
   input  wire logic [KEY_W-1:0] req_lookup_key,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_status,
   output logic      [MAC_W-1:0] rsp_matched_mac
);

   // Address width of the ring, and a count width that holds both the
   // register value and the depth itself.
   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = (LEN_W > AW + 1) ? LEN_W : AW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] len_ff;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [AW-1:0]    last_ff, last_in;
   logic [AW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic             pend_ff, pend_in;
   logic             res_status_ff, res_status_in;
   logic [MAC_W-1:0] res_mac_ff, res_mac_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_status_ff, rsp_status_in;
   logic [MAC_W-1:0] rsp_mac_ff, rsp_mac_in;

   logic             req_fire;
   logic [CW-1:0]    len_ext;
   logic [CW-1:0]    used_len;
   logic [CW-1:0]    idx_ext;
   logic             wr_en;
   logic             rd_en;
   logic [KEY_W-1:0] rd_key;
   logic [MAC_W-1:0] rd_mac;
   logic             hit;
   logic             out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // A length above the table depth saturates at the depth.
   assign len_ext  = CW'(len_ff);
   assign used_len = (len_ext > DEPTH_C) ? DEPTH_C : len_ext;

   // Writes beyond the table are dropped.
   assign idx_ext = CW'(req_entry_index);
   assign wr_en   = req_fire && (req_func == FUNC_WRITE) && (idx_ext < DEPTH_C);
   assign rd_en   = (state_ff == S_SCAN);

   hrol_ring_mem #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ext[AW-1:0]),
      .wr_key  (req_entry_key),
      .wr_mac  (req_entry_mac),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_key  (rd_key),
      .rd_mac  (rd_mac)
   );

   // The shared comparator: the entry read last cycle either wins, or it is
   // the last valid entry and wins by default.
   assign hit      = pend_ff && ((key_ff < rd_key) || (cmp_idx_ff == last_ff));
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      cmp_idx_in    = cmp_idx_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_mac_in    = res_mac_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_mac_in    = rsp_mac_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_func == FUNC_LOOKUP)) begin
               key_in  = req_lookup_key;
               addr_in = '0;
               pend_in = 1'b0;
               if (used_len == '0) begin
                  res_status_in = ST_EMPTY;
                  res_mac_in    = '0;
                  state_in      = S_DONE;
               end else begin
                  last_in  = AW'(used_len - CW'(1));
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Read the next entry while the previous one is compared; the
            // address parks on the last valid entry.
            pend_in    = 1'b1;
            cmp_idx_in = addr_ff;
            if (addr_ff != last_ff) begin
               addr_in = addr_ff + AW'(1);
            end
            if (hit) begin
               res_status_in = ST_FOUND;
               res_mac_in    = rd_mac;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_mac_in    = res_mac_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      addr_ff       <= addr_in;
      last_ff       <= last_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_mac_ff    <= res_mac_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mac_ff    <= rsp_mac_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_matched_mac = rsp_mac_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/hrol_checker.sv =====
// Port-level checks for the hash ring owner lookup, bound to its top level.
// Depends on hrol_pkg and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none
module hrol_checker
   import hrol_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             req_func,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic             rsp_status,
   input wire logic [MAC_W-1:0] rsp_matched_mac
);

   `ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "response valid after reset")
   `ASSERT_CLK(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")
   `ASSERT_CLK(a_empty_mac_zero, clock, reset, rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_matched_mac == '0), "empty ring with nonzero MAC")
   `ASSERT_CLK(a_lookup_busy, clock, reset, req_valid && req_ready && (req_func == FUNC_LOOKUP) |=> !req_ready, "ready during lookup")
   `ASSERT_CLK(a_write_no_rsp, clock, reset, req_valid && req_ready && (req_func == FUNC_WRITE) && !rsp_valid |=> !rsp_valid, "response from a write")

endmodule

bind hash_ring_owner_lookup hrol_checker u_hrol_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_func        (req_func),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_matched_mac (rsp_matched_mac)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the hash ring owner lookup block.
// Depends on hrol_pkg and the hash_ring_owner_lookup RTL; reads no files.
// A model of the ring predicts every lookup response under bursts and stalls.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hrol_pkg::*;

   localparam int RING_DEPTH     = RING_DEPTH_DEF;
   // This pause covers any lookup that may still be in flight.
   localparam int SETTLE_CYCLES  = RING_DEPTH + 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 950;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic             status;
      logic [MAC_W-1:0] mac;
   } owner_result_type;

   // Receiver behaviors; the receiver switches among them at random.
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_MOSTLY,
      RX_PERIODIC,
      RX_SPARSE
   } rx_mode_type;

   // Block inputs, all known from time zero.
   logic             clock           = 1'b0;
   logic             reset           = 1'b1;
   logic             csr_wr_en       = 1'b0;
   logic [LEN_W-1:0] csr_wr_data     = '0;
   logic             req_valid       = 1'b0;
   logic             req_func        = FUNC_WRITE;
   logic [IDX_W-1:0] req_entry_index = '0;
   logic [KEY_W-1:0] req_entry_key   = '0;
   logic [MAC_W-1:0] req_entry_mac   = '0;
   logic [KEY_W-1:0] req_lookup_key  = '0;
   logic             rsp_ready       = 1'b0;

   // Block outputs.
   logic             req_ready;
   logic             rsp_valid;
   logic             rsp_status;
   logic [MAC_W-1:0] rsp_matched_mac;

   // Predictor state: a private copy of the ring and of the length register.
   logic [KEY_W-1:0] owner_keys [RING_DEPTH];
   logic [MAC_W-1:0] owner_macs [RING_DEPTH];
   logic [LEN_W-1:0] ring_len_cfg = '0;
   owner_result_type expected_owners [$];

   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;
   int unsigned items_sent     = 0;

   // Sender burst control, shared by the stimulus tasks.
   int unsigned burst_left    = 0;
   bit          steady_sender = 1'b0;

   // Receiver state. The stimulus flips stall_token to ask for a long hold-off.
   logic        stall_token = 1'b0;
   logic        stall_seen  = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned rx_cycle    = 0;
   rx_mode_type rx_mode     = RX_ALWAYS;

   hash_ring_owner_lookup #(
      .RING_DEPTH(RING_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_entry_index(req_entry_index),
      .req_entry_key  (req_entry_key),
      .req_entry_mac  (req_entry_mac),
      .req_lookup_key (req_lookup_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_matched_mac(rsp_matched_mac)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Owner selection: the first entry whose key is strictly greater than the
   // probe, or else the last entry in use. The length register saturates at
   // the table depth, and an empty ring answers with the empty status.
   function automatic owner_result_type predict_owner(input logic [KEY_W-1:0] probe);
      owner_result_type r;
      int unsigned      n;
      int unsigned      pick;
      bit               found;
      n     = (ring_len_cfg > RING_DEPTH) ? RING_DEPTH : ring_len_cfg;
      found = 1'b0;
      if (n == 0) begin
         r.status = ST_EMPTY;
         r.mac    = '0;
         return r;
      end
      pick = n - 1;
      for (int unsigned i = 0; i < n; i++) begin
         if (!found && probe < owner_keys[i]) begin
            pick  = i;
            found = 1'b1;
         end
      end
      r.status = ST_FOUND;
      r.mac    = owner_macs[pick];
      return r;
   endfunction

   // Follows every accepted request and register write. Ring writes update the
   // private copy; lookups queue their predicted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            ring_len_cfg <= csr_wr_data;
         end
         if (req_valid && req_ready) begin
            if (req_func == FUNC_WRITE) begin
               owner_keys[req_entry_index] <= req_entry_key;
               owner_macs[req_entry_index] <= req_entry_mac;
            end else begin
               expected_owners.push_back(predict_owner(req_lookup_key));
            end
         end
      end
   end

   task automatic note_mismatch(input string what, input logic [MAC_W-1:0] want,
                                input logic [MAC_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
      end
   endtask

   // Every accepted response is matched against the oldest prediction.
   always @(posedge clock) begin : check_response
      owner_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_owners.size() == 0) begin
            note_mismatch("unexpected response, mac", '0, rsp_matched_mac);
         end else begin
            want = expected_owners.pop_front();
            if (rsp_status !== want.status) begin
               note_mismatch("status", MAC_W'(want.status), MAC_W'(rsp_status));
            end
            if (rsp_matched_mac !== want.mac) begin
               note_mismatch("matched_mac", want.mac, rsp_matched_mac);
            end
         end
      end
   end

   // Receiver. A flipped stall_token starts a hold-off that this process
   // counts down itself; otherwise it follows the current pattern.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 128 == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
      end
      if (stall_token != stall_seen) begin
         stall_seen <= stall_token;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:   rsp_ready <= 1'b1;
            RX_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_ready <= (rx_cycle % 5 >= 2);
            default:     rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog: too long without any request, response or register write
   // means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [MAC_W-1:0] rand_mac();
      return MAC_W'({$urandom, $urandom});
   endfunction

   // Probe keys cluster on ring points (equal and one off on either side) so
   // that the strict comparison is exercised, with the key extremes mixed in.
   function automatic logic [KEY_W-1:0] pick_probe_key();
      logic [KEY_W-1:0] point;
      point = owner_keys[$urandom_range(0, RING_DEPTH - 1)];
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return point;
         4:       return point - KEY_W'(1);
         5:       return point + KEY_W'(1);
         default: return KEY_W'($urandom);
      endcase
   endfunction

   // Sends one request and returns at the edge that accepts it. Valid stays
   // high into the next request unless a burst ends and a gap follows.
   task automatic send_request(input logic func, input logic [IDX_W-1:0] idx,
                               input logic [KEY_W-1:0] ekey, input logic [MAC_W-1:0] emac,
                               input logic [KEY_W-1:0] lkey);
      if (burst_left == 0) begin
         if (!steady_sender) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_func        <= func;
      req_entry_index <= idx;
      req_entry_key   <= ekey;
      req_entry_mac   <= emac;
      req_lookup_key  <= lkey;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Unused fields carry random values so that the block must ignore them.
   task automatic send_write(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] ekey,
                             input logic [MAC_W-1:0] emac);
      send_request(FUNC_WRITE, idx, ekey, emac, KEY_W'($urandom));
   endtask

   task automatic send_lookup(input logic [KEY_W-1:0] probe);
      send_request(FUNC_LOOKUP, IDX_W'($urandom), KEY_W'($urandom), rand_mac(), probe);
   endtask

   // Stops offering requests and waits until every predicted response has
   // come back, then lets any scan still running finish.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_owners.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The length register is only written while the block is idle.
   task automatic write_ring_length(input int unsigned len);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len[LEN_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // An empty ring answers with the empty status whatever the probe is.
   task automatic test_empty_ring();
      write_ring_length(0);
      send_request(FUNC_LOOKUP, '1, '1, '1, '0);
      send_request(FUNC_LOOKUP, '0, '0, '0, '1);
   endtask

   // Small ring with equal keys and both key extremes: checks the strict
   // comparison, the fall-back to the last entry and a one-entry ring.
   task automatic test_scan_order();
      send_write(IDX_W'(0), 32'h0000_0000, '0);
      send_write(IDX_W'(1), 32'h0000_0100, '1);
      send_write(IDX_W'(2), 32'h8000_0000, rand_mac());
      send_write(IDX_W'(3), 32'h8000_0000, rand_mac());
      send_write(IDX_W'(4), 32'hFFFF_FFFF, rand_mac());
      write_ring_length(5);
      send_lookup(32'h0000_0000);
      send_lookup(32'h0000_00FF);
      send_lookup(32'h0000_0100);
      send_lookup(32'h7FFF_FFFF);
      send_lookup(32'h8000_0000);
      send_lookup(32'hFFFF_FFFE);
      send_lookup(32'hFFFF_FFFF);
      write_ring_length(1);
      send_lookup(32'hFFFF_FFFF);
      send_lookup(32'h0000_0000);
   endtask

   // Writes every entry with ascending keys so that scans run deep and no
   // lookup can ever reach an entry that was never written.
   task automatic test_fill_ring();
      for (int unsigned i = 0; i < RING_DEPTH; i++) begin
         send_write(IDX_W'(i), KEY_W'((i << 26) | $urandom_range(0, (1 << 26) - 1)),
                    rand_mac());
      end
   endtask

   // Lengths above the table depth behave as the full table.
   task automatic test_length_saturation();
      int unsigned lens [3];
      lens = '{RING_DEPTH, RING_DEPTH + 1, (1 << LEN_W) - 1};
      foreach (lens[n]) begin
         write_ring_length(lens[n]);
         send_lookup('1);
         for (int i = 0; i < 4; i++) begin
            send_lookup(pick_probe_key());
         end
      end
   endtask

   // The receiver holds off for a long stretch while lookups keep coming, so
   // the output register and the scan both fill and req_ready goes low.
   task automatic test_output_backpressure();
      write_ring_length(RING_DEPTH);
      steady_sender = 1'b1;
      stall_token <= ~stall_token;
      for (int i = 0; i < 24; i++) begin
         send_lookup(pick_probe_key());
      end
      steady_sender = 1'b0;
   endtask

   // Phases of mixed traffic, each with its own ring length. Rewrites mostly
   // keep the ring in ascending order so that lookups still scan far.
   task automatic test_random_traffic();
      int unsigned      len;
      int unsigned      count;
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] lo;
      logic [KEY_W-1:0] hi;
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = 1;
            2:       len = RING_DEPTH;
            3:       len = $urandom_range(RING_DEPTH + 1, (1 << LEN_W) - 1);
            4, 5:    len = $urandom_range(1, 8);
            default: len = $urandom_range(1, RING_DEPTH);
         endcase
         write_ring_length(len);
         steady_sender = ($urandom_range(0, 3) == 0);
         count = $urandom_range(40, 100);
         for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               idx = IDX_W'($urandom);
               lo  = (idx == 0) ? '0 : owner_keys[idx - 1];
               hi  = (idx == RING_DEPTH - 1) ? '1 : owner_keys[idx + 1];
               if ($urandom_range(0, 4) != 0) begin
                  send_write(idx, KEY_W'($urandom_range(hi, lo)), rand_mac());
               end else begin
                  send_write(idx, KEY_W'($urandom), rand_mac());
               end
            end else begin
               send_lookup(pick_probe_key());
            end
         end
      end
      steady_sender = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_ring();
      test_scan_order();
      test_fill_ring();
      test_length_saturation();
      test_output_backpressure();
      test_random_traffic();

      wait_drained();
      if (expected_owners.size() != 0) begin
         mismatch_count += expected_owners.size();
      end
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
